// File: rtl/kfi_pkg.sv
// Shared types, constants and the easing coefficient table of the keyframe interpolator.
package kfi_pkg;

  localparam int TIME_BITS     = 16;
  localparam int VALUE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_KEYFRAMES = 64;
  localparam int INDEX_BITS    = 6;
  localparam int COUNT_BITS    = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int EASE_STEPS    = 5;
  localparam int COEF_BITS     = 9;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COUNT,
    CFG_DURATION,
    CFG_STANDARD,
    CFG_MODE
  } kfi_cfg_e;

  typedef struct packed {
    logic                         cmd;
    logic [INDEX_BITS-1:0]        entry_index;
    logic [TIME_BITS-1:0]         key_position;
    logic signed [VALUE_BITS-1:0] key_value;
    logic                         ease_toward;
    logic                         ease_away;
    logic [TIME_BITS-1:0]         query_time;
  } kfi_in_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] result_value;
    logic                         on_keyframe;
    logic [1:0]                   status;
  } kfi_out_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         pos;
    logic signed [VALUE_BITS-1:0] value;
    logic                         away;
    logic                         toward;
  } kfi_entry_t;

  localparam int ENTRY_BITS = $bits(kfi_entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_STEP_SCAN,
    S_LIN_SCAN,
    S_LIN_PAIR,
    S_DIVIDE,
    S_EASE_SEL,
    S_EASE_MUL,
    S_EASE_ADD,
    S_EASE_CLAMP,
    S_MIX_MUL,
    S_MIX_ADD,
    S_FINISH
  } kfi_state_e;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_NONE,
    RES_WRITE,
    RES_RANGE,
    RES_STD,
    RES_KEY,
    RES_PAIR,
    RES_MIX
  } kfi_res_e;

  typedef enum logic [1:0] {
    IDX_HOLD,
    IDX_LOAD,
    IDX_INC,
    IDX_DEC
  } kfi_idx_e;

  typedef enum logic [2:0] {
    T_HOLD,
    T_ZERO,
    T_ONE,
    T_SHIFT,
    T_CLAMP
  } kfi_t_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_INIT,
    ACC_STEP
  } kfi_acc_e;

  typedef enum logic [1:0] {
    EASE_NONE,
    EASE_SMOOTH,
    EASE_IN,
    EASE_OUT
  } kfi_ease_e;

  typedef struct packed {
    logic     ram_we;
    logic     latch_query;
    kfi_idx_e idx_op;
    logic     capture_pair;
    logic     div_init;
    logic     div_step;
    kfi_t_e   t_op;
    kfi_acc_e acc_op;
    logic     mul_en;
    logic     mul_mix;
    kfi_res_e res_op;
    logic     load_out;
  } kfi_cmd_t;

  typedef struct packed {
    logic time_over;
    logic linear;
    logic count_zero;
    logic idx_zero;
    logic step_hit;
    logic lin_hit;
    logic lin_pass;
    logic lin_end;
    logic same_val;
    logic rel_le0;
    logic rel_ge_span;
    logic div_last;
    logic ease_bypass;
    logic ease_last;
  } kfi_stat_t;

  // Horner coefficients in whole units, step 0 is the leading term.
  function automatic logic signed [COEF_BITS-1:0] ease_coef(kfi_ease_e kind,
                                                            logic [2:0] step);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    unique case (kind)
      EASE_SMOOTH: begin
        unique case (step)
          3'd0:    c = 9'sd6;
          3'd1:    c = -9'sd15;
          3'd2:    c = 9'sd10;
          default: c = '0;
        endcase
      end
      EASE_IN: begin
        unique case (step)
          3'd0:    c = 9'sd48;
          3'd1:    c = -9'sd64;
          3'd2:    c = 9'sd24;
          default: c = '0;
        endcase
      end
      EASE_OUT: begin
        unique case (step)
          3'd0:    c = 9'sd48;
          3'd1:    c = -9'sd176;
          3'd2:    c = 9'sd248;
          3'd3:    c = -9'sd168;
          3'd4:    c = 9'sd56;
          3'd5:    c = -9'sd7;
          default: c = '0;
        endcase
      end
      EASE_NONE: c = '0;
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/kfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/kfi_datapath.sv
// Datapath: config registers, keyframe table, scan frames, divider, easing and mix.
module kfi_datapath #(
  parameter int MAX_KEYFRAMES = kfi_pkg::MAX_KEYFRAMES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kfi_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [kfi_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  kfi_pkg::kfi_in_t                   in_data_i,
  input  kfi_pkg::kfi_cmd_t                  cmd_i,
  output kfi_pkg::kfi_stat_t                 stat_o,
  output kfi_pkg::kfi_out_t                  out_data_o
);

  localparam int TB     = kfi_pkg::TIME_BITS;
  localparam int VB     = kfi_pkg::VALUE_BITS;
  localparam int FB     = kfi_pkg::FRAC_BITS;
  localparam int AW     = $clog2(MAX_KEYFRAMES);
  localparam int CW     = $clog2(MAX_KEYFRAMES + 1);
  localparam int POS_W  = TB + 2;
  localparam int DIV_W  = TB + 2;
  localparam int DCW    = $clog2(FB);
  localparam int T_W    = FB + 1;
  localparam int ACC_W  = VB + 2;
  localparam int PROD_W = T_W + 1 + ACC_W;

  localparam logic [T_W-1:0] T_ONE  = T_W'(1) << FB;
  localparam logic [T_W-1:0] T_HALF = T_W'(1) << (FB - 1);
  localparam logic signed [ACC_W-1:0]  ACC_ONE  = ACC_W'(1) <<< FB;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FB - 1);
  localparam logic signed [PROD_W-1:0] RND_LOW  = RND_HALF - PROD_W'(1);
  localparam logic signed [POS_W-1:0]  POS_NONE = -POS_W'(1);

  // configuration
  logic [kfi_pkg::COUNT_BITS-1:0] cfg_count_q;
  logic [TB-1:0]                  cfg_dur_q;
  logic signed [VB-1:0]           cfg_std_q;
  logic                           cfg_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_count_q <= '0;
      cfg_dur_q   <= '0;
      cfg_std_q   <= '0;
      cfg_mode_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (kfi_pkg::kfi_cfg_e'(cfg_idx_i))
        kfi_pkg::CFG_COUNT:    cfg_count_q <= cfg_data_i[kfi_pkg::COUNT_BITS-1:0];
        kfi_pkg::CFG_DURATION: cfg_dur_q   <= cfg_data_i[TB-1:0];
        kfi_pkg::CFG_STANDARD: cfg_std_q   <= cfg_data_i[VB-1:0];
        kfi_pkg::CFG_MODE:     cfg_mode_q  <= cfg_data_i[0];
        default:               cfg_mode_q  <= cfg_mode_q;
      endcase
    end
  end

  logic [CW-1:0] count_eff;
  logic          count_zero;

  always_comb begin
    if (int'(cfg_count_q) > MAX_KEYFRAMES) begin
      count_eff = CW'(MAX_KEYFRAMES);
    end else begin
      count_eff = CW'(cfg_count_q);
    end
  end

  assign count_zero = (count_eff == '0);

  // keyframe table
  logic [kfi_pkg::ENTRY_BITS-1:0] ram_rdata;
  logic [CW-1:0]                  idx_q, idx_d;
  logic                           ram_we;
  kfi_pkg::kfi_entry_t            wr_entry, rd_entry;

  assign ram_we = cmd_i.ram_we && (int'(in_data_i.entry_index) < MAX_KEYFRAMES);

  always_comb begin
    wr_entry.pos    = in_data_i.key_position;
    wr_entry.value  = in_data_i.key_value;
    wr_entry.away   = in_data_i.ease_away;
    wr_entry.toward = in_data_i.ease_toward;
  end

  kfi_ram #(
    .WIDTH(kfi_pkg::ENTRY_BITS),
    .DEPTH(MAX_KEYFRAMES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(AW'(in_data_i.entry_index)),
    .wdata_i(wr_entry),
    .raddr_i(idx_d[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = kfi_pkg::kfi_entry_t'(ram_rdata);

  // scan index: read data always belongs to idx_q
  always_comb begin
    unique case (cmd_i.idx_op)
      kfi_pkg::IDX_LOAD: idx_d = cfg_mode_q ? '0 : (count_eff - 1'b1);
      kfi_pkg::IDX_INC:  idx_d = idx_q + 1'b1;
      kfi_pkg::IDX_DEC:  idx_d = idx_q - 1'b1;
      kfi_pkg::IDX_HOLD: idx_d = idx_q;
      default:           idx_d = idx_q;
    endcase
  end

  logic [TB-1:0]                  time_q;
  logic signed [VB-1:0]           prev_value_q;
  logic signed [POS_W-1:0]        prev_pos_q;
  logic                           prev_away_q;
  logic signed [VB-1:0]           a_value_q, b_value_q;
  logic signed [POS_W-1:0]        a_pos_q, b_pos_q;
  logic                           a_away_q, b_toward_q;

  logic signed [POS_W-1:0] time_s, rd_pos_s, dur_s;
  logic                    lin_end, std_end, std_start;
  logic signed [VB-1:0]    p1_value, p2_value;
  logic signed [POS_W-1:0] p1_pos, p2_pos;
  logic                    p1_away, p2_toward;

  assign time_s   = $signed({2'b00, time_q});
  assign rd_pos_s = $signed({2'b00, rd_entry.pos});
  assign dur_s    = $signed({2'b00, cfg_dur_q});
  assign lin_end  = (idx_q == count_eff);
  assign std_end  = count_zero || (prev_pos_q != dur_s);
  assign std_start = count_zero || (rd_entry.pos != '0);

  // neighbors: virtual endpoints at zero and at the duration
  always_comb begin
    if (!lin_end) begin
      p2_value  = rd_entry.value;
      p2_pos    = rd_pos_s;
      p2_toward = rd_entry.toward;
    end else if (std_end) begin
      p2_value  = cfg_std_q;
      p2_pos    = dur_s;
      p2_toward = 1'b0;
    end else begin
      p2_value  = '0;
      p2_pos    = POS_NONE;
      p2_toward = 1'b0;
    end
    if (idx_q != '0) begin
      p1_value = prev_value_q;
      p1_pos   = prev_pos_q;
      p1_away  = prev_away_q;
    end else if (std_start) begin
      p1_value = cfg_std_q;
      p1_pos   = '0;
      p1_away  = 1'b0;
    end else begin
      p1_value = '0;
      p1_pos   = POS_NONE;
      p1_away  = 1'b0;
    end
  end

  // t formation
  logic signed [POS_W-1:0] rel, span;
  logic [DIV_W-1:0]        rem_q, rem_d, rem_x2, span_u;
  logic                    div_ge;
  logic [DCW-1:0]          div_cnt_q;

  assign rel    = time_s - a_pos_q;
  assign span   = b_pos_q - a_pos_q;
  assign span_u = DIV_W'(span);
  assign rem_x2 = {rem_q[DIV_W-2:0], 1'b0};
  assign div_ge = (rem_x2 >= span_u);
  assign rem_d  = div_ge ? (rem_x2 - span_u) : rem_x2;

  // easing and mix share one multiplier
  logic [T_W-1:0]                      t_q;
  kfi_pkg::kfi_ease_e                  kind, kind_q;
  logic [2:0]                          step_q;
  logic signed [ACC_W-1:0]             acc_q, acc_init, acc_step, diff, mul_b;
  logic signed [kfi_pkg::COEF_BITS-1:0] coef0, coefn;
  logic signed [T_W:0]                 mul_a;
  logic signed [PROD_W-1:0]            prod_q, prod_d, rnd_full;
  logic [T_W-1:0]                      t_clamp;
  logic signed [VB-1:0]                mix_val;

  always_comb begin
    priority if (a_away_q && b_toward_q) begin
      kind = kfi_pkg::EASE_SMOOTH;
    end else if (a_away_q) begin
      kind = (t_q >= T_HALF) ? kfi_pkg::EASE_NONE : kfi_pkg::EASE_IN;
    end else if (b_toward_q) begin
      kind = (t_q <= T_HALF) ? kfi_pkg::EASE_NONE : kfi_pkg::EASE_OUT;
    end else begin
      kind = kfi_pkg::EASE_NONE;
    end
  end

  assign coef0    = kfi_pkg::ease_coef(kind, 3'd0);
  assign coefn    = kfi_pkg::ease_coef(kind_q, step_q);
  assign acc_init = ACC_W'(coef0) <<< FB;
  assign diff     = ACC_W'(b_value_q) - ACC_W'(a_value_q);
  assign mul_a    = $signed({1'b0, t_q});
  assign mul_b    = cmd_i.mul_mix ? diff : acc_q;
  assign prod_d   = mul_a * mul_b;
  // round half away from zero
  assign rnd_full = (prod_q + (prod_q[PROD_W-1] ? RND_LOW : RND_HALF)) >>> FB;
  assign acc_step = ACC_W'(rnd_full) + (ACC_W'(coefn) <<< FB);
  assign mix_val  = a_value_q + VB'(rnd_full);

  always_comb begin
    priority if (acc_q[ACC_W-1]) begin
      t_clamp = '0;
    end else if (acc_q > ACC_ONE) begin
      t_clamp = T_ONE;
    end else begin
      t_clamp = T_W'(acc_q);
    end
  end

  kfi_pkg::kfi_out_t res_q, out_q;

  // control counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      div_cnt_q <= '0;
      step_q    <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.acc_op == kfi_pkg::ACC_INIT) begin
        step_q <= 3'd1;
      end else if (cmd_i.acc_op == kfi_pkg::ACC_STEP) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_query) begin
      time_q <= in_data_i.query_time;
    end
    if (cmd_i.idx_op == kfi_pkg::IDX_INC) begin
      prev_value_q <= rd_entry.value;
      prev_pos_q   <= rd_pos_s;
      prev_away_q  <= rd_entry.away;
    end
    if (cmd_i.capture_pair) begin
      a_value_q  <= p1_value;
      a_pos_q    <= p1_pos;
      a_away_q   <= p1_away;
      b_value_q  <= p2_value;
      b_pos_q    <= p2_pos;
      b_toward_q <= p2_toward;
    end
    if (cmd_i.div_init) begin
      rem_q <= DIV_W'(rel);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
    end
    unique case (cmd_i.t_op)
      kfi_pkg::T_ZERO:  t_q <= '0;
      kfi_pkg::T_ONE:   t_q <= T_ONE;
      kfi_pkg::T_SHIFT: t_q <= {t_q[T_W-2:0], div_ge};
      kfi_pkg::T_CLAMP: t_q <= t_clamp;
      kfi_pkg::T_HOLD:  t_q <= t_q;
      default:          t_q <= t_q;
    endcase
    unique case (cmd_i.acc_op)
      kfi_pkg::ACC_INIT: begin
        acc_q  <= acc_init;
        kind_q <= kind;
      end
      kfi_pkg::ACC_STEP: acc_q <= acc_step;
      kfi_pkg::ACC_HOLD: acc_q <= acc_q;
      default:           acc_q <= acc_q;
    endcase
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    unique case (cmd_i.res_op)
      kfi_pkg::RES_NONE:  res_q <= '{result_value: '0, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_OK};
      kfi_pkg::RES_WRITE: res_q <= '{result_value: '0, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_WRITE};
      kfi_pkg::RES_RANGE: res_q <= '{result_value: '0, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_RANGE};
      kfi_pkg::RES_STD:   res_q <= '{result_value: cfg_std_q, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_OK};
      kfi_pkg::RES_KEY:   res_q <= '{result_value: rd_entry.value, on_keyframe: 1'b1,
                                     status: kfi_pkg::ST_OK};
      kfi_pkg::RES_PAIR:  res_q <= '{result_value: b_value_q, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_OK};
      kfi_pkg::RES_MIX:   res_q <= '{result_value: mix_val, on_keyframe: 1'b0,
                                     status: kfi_pkg::ST_OK};
      kfi_pkg::RES_HOLD:  res_q <= res_q;
      default:            res_q <= res_q;
    endcase
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

  always_comb begin
    stat_o.time_over   = (time_q > cfg_dur_q);
    stat_o.linear      = cfg_mode_q;
    stat_o.count_zero  = count_zero;
    stat_o.idx_zero    = (idx_q == '0);
    stat_o.step_hit    = (rd_entry.pos <= time_q);
    stat_o.lin_hit     = !lin_end && (time_s == p2_pos);
    stat_o.lin_pass    = (time_s > p2_pos);
    stat_o.lin_end     = lin_end;
    stat_o.same_val    = (a_value_q == b_value_q);
    stat_o.rel_le0     = rel[POS_W-1] || (rel == '0);
    stat_o.rel_ge_span = (rel >= span);
    stat_o.div_last    = (div_cnt_q == DCW'(FB - 1));
    stat_o.ease_bypass = (kind == kfi_pkg::EASE_NONE);
    stat_o.ease_last   = (step_q == 3'(kfi_pkg::EASE_STEPS));
  end

endmodule

// File: rtl/kfi_ctrl.sv
// Controller: sequences writes, table scans, division, easing and the output register.
module kfi_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  input  logic               out_stall_i,
  input  kfi_pkg::kfi_stat_t stat_i,
  output kfi_pkg::kfi_cmd_t  cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);

  kfi_pkg::kfi_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kfi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_cmd_i == kfi_pkg::CMD_WRITE) ? kfi_pkg::S_FINISH
                                                      : kfi_pkg::S_DISPATCH;
        end
      end
      kfi_pkg::S_DISPATCH: begin
        priority if (stat_i.time_over) begin
          state_d = kfi_pkg::S_FINISH;
        end else if (stat_i.linear) begin
          state_d = kfi_pkg::S_LIN_SCAN;
        end else if (stat_i.count_zero) begin
          state_d = kfi_pkg::S_FINISH;
        end else begin
          state_d = kfi_pkg::S_STEP_SCAN;
        end
      end
      kfi_pkg::S_STEP_SCAN: begin
        if (stat_i.step_hit || stat_i.idx_zero) begin
          state_d = kfi_pkg::S_FINISH;
        end
      end
      kfi_pkg::S_LIN_SCAN: begin
        priority if (stat_i.lin_hit) begin
          state_d = kfi_pkg::S_FINISH;
        end else if (stat_i.lin_pass) begin
          if (stat_i.lin_end) begin
            state_d = kfi_pkg::S_FINISH;
          end
        end else begin
          state_d = kfi_pkg::S_LIN_PAIR;
        end
      end
      kfi_pkg::S_LIN_PAIR: begin
        priority if (stat_i.same_val) begin
          state_d = kfi_pkg::S_FINISH;
        end else if (stat_i.rel_le0 || stat_i.rel_ge_span) begin
          state_d = kfi_pkg::S_EASE_SEL;
        end else begin
          state_d = kfi_pkg::S_DIVIDE;
        end
      end
      kfi_pkg::S_DIVIDE: begin
        if (stat_i.div_last) begin
          state_d = kfi_pkg::S_EASE_SEL;
        end
      end
      kfi_pkg::S_EASE_SEL: begin
        state_d = stat_i.ease_bypass ? kfi_pkg::S_MIX_MUL : kfi_pkg::S_EASE_MUL;
      end
      kfi_pkg::S_EASE_MUL:   state_d = kfi_pkg::S_EASE_ADD;
      kfi_pkg::S_EASE_ADD: begin
        state_d = stat_i.ease_last ? kfi_pkg::S_EASE_CLAMP : kfi_pkg::S_EASE_MUL;
      end
      kfi_pkg::S_EASE_CLAMP: state_d = kfi_pkg::S_MIX_MUL;
      kfi_pkg::S_MIX_MUL:    state_d = kfi_pkg::S_MIX_ADD;
      kfi_pkg::S_MIX_ADD:    state_d = kfi_pkg::S_FINISH;
      kfi_pkg::S_FINISH: begin
        if (out_free) begin
          state_d = kfi_pkg::S_IDLE;
        end
      end
      default: state_d = kfi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.ram_we       = 1'b0;
    cmd_o.latch_query  = 1'b0;
    cmd_o.idx_op       = kfi_pkg::IDX_HOLD;
    cmd_o.capture_pair = 1'b0;
    cmd_o.div_init     = 1'b0;
    cmd_o.div_step     = 1'b0;
    cmd_o.t_op         = kfi_pkg::T_HOLD;
    cmd_o.acc_op       = kfi_pkg::ACC_HOLD;
    cmd_o.mul_en       = 1'b0;
    cmd_o.mul_mix      = 1'b0;
    cmd_o.res_op       = kfi_pkg::RES_HOLD;
    cmd_o.load_out     = 1'b0;
    unique case (state_q)
      kfi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (in_cmd_i == kfi_pkg::CMD_WRITE) begin
            cmd_o.ram_we = 1'b1;
            cmd_o.res_op = kfi_pkg::RES_WRITE;
          end else begin
            cmd_o.latch_query = 1'b1;
          end
        end
      end
      kfi_pkg::S_DISPATCH: begin
        priority if (stat_i.time_over) begin
          cmd_o.res_op = kfi_pkg::RES_RANGE;
        end else if (!stat_i.linear && stat_i.count_zero) begin
          cmd_o.res_op = kfi_pkg::RES_STD;
        end else begin
          cmd_o.idx_op = kfi_pkg::IDX_LOAD;
        end
      end
      kfi_pkg::S_STEP_SCAN: begin
        priority if (stat_i.step_hit) begin
          cmd_o.res_op = kfi_pkg::RES_KEY;
        end else if (stat_i.idx_zero) begin
          cmd_o.res_op = kfi_pkg::RES_STD;
        end else begin
          cmd_o.idx_op = kfi_pkg::IDX_DEC;
        end
      end
      kfi_pkg::S_LIN_SCAN: begin
        priority if (stat_i.lin_hit) begin
          cmd_o.res_op = kfi_pkg::RES_KEY;
        end else if (stat_i.lin_pass) begin
          if (stat_i.lin_end) begin
            cmd_o.res_op = kfi_pkg::RES_NONE;
          end else begin
            cmd_o.idx_op = kfi_pkg::IDX_INC;
          end
        end else begin
          cmd_o.capture_pair = 1'b1;
        end
      end
      kfi_pkg::S_LIN_PAIR: begin
        priority if (stat_i.same_val) begin
          cmd_o.res_op = kfi_pkg::RES_PAIR;
        end else if (stat_i.rel_le0) begin
          cmd_o.t_op = kfi_pkg::T_ZERO;
        end else if (stat_i.rel_ge_span) begin
          cmd_o.t_op = kfi_pkg::T_ONE;
        end else begin
          cmd_o.div_init = 1'b1;
          cmd_o.t_op     = kfi_pkg::T_ZERO;
        end
      end
      kfi_pkg::S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        cmd_o.t_op     = kfi_pkg::T_SHIFT;
      end
      kfi_pkg::S_EASE_SEL:   cmd_o.acc_op = kfi_pkg::ACC_INIT;
      kfi_pkg::S_EASE_MUL:   cmd_o.mul_en = 1'b1;
      kfi_pkg::S_EASE_ADD:   cmd_o.acc_op = kfi_pkg::ACC_STEP;
      kfi_pkg::S_EASE_CLAMP: cmd_o.t_op   = kfi_pkg::T_CLAMP;
      kfi_pkg::S_MIX_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_mix = 1'b1;
      end
      kfi_pkg::S_MIX_ADD:    cmd_o.res_op = kfi_pkg::RES_MIX;
      kfi_pkg::S_FINISH:     cmd_o.load_out = out_free;
      default:               cmd_o.load_out = 1'b0;
    endcase
  end

  // hold the result until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if ((state_q == kfi_pkg::S_FINISH) && out_free) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kfi_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != kfi_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/keyframe_interpolator.sv
// Keyframe interpolator: step and eased linear lookup over a written keyframe table.
// Write item: entry written on acceptance; status registered, then loaded out.
// Query item: step mode scans down from the last entry, linear mode scans up and then
// divides serially and eases (one table entry read per cycle, 5 easing multiply steps).
// Next item is taken when idle after the result loads; a stalled full output holds input.
// Reset clears the config registers and control; the table is undefined until written.
module keyframe_interpolator #(
  parameter int MAX_KEYFRAMES = kfi_pkg::MAX_KEYFRAMES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kfi_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [kfi_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  kfi_pkg::kfi_in_t                  in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output kfi_pkg::kfi_out_t                 out_data_o
);

  kfi_pkg::kfi_cmd_t  cmd;
  kfi_pkg::kfi_stat_t stat;

  kfi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  kfi_datapath #(
    .MAX_KEYFRAMES(MAX_KEYFRAMES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_data_o(out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a second item right after acceptance");

  a_write_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == kfi_pkg::ST_WRITE) |->
      (out_data_o.result_value == '0) && !out_data_o.on_keyframe)
    else $error("write item result carries a value");

  a_range_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == kfi_pkg::ST_RANGE) |->
      (out_data_o.result_value == '0) && !out_data_o.on_keyframe)
    else $error("out of range query carries a value");

  a_key_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.on_keyframe |-> (out_data_o.status == kfi_pkg::ST_OK))
    else $error("keyframe hit with a non-ok status");
`endif

endmodule
